// ----- rtl/rvdec_pkg.sv -----
package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned GroupWidth = 4;

  typedef logic [CodeWidth-1:0]  code_t;
  typedef logic [GroupWidth-1:0] grp_t;

  // Extension groups
  localparam grp_t GrpI        = 4'd0;
  localparam grp_t GrpM        = 4'd1;
  localparam grp_t GrpA        = 4'd2;
  localparam grp_t GrpF        = 4'd3;
  localparam grp_t GrpD        = 4'd4;
  localparam grp_t GrpQ        = 4'd5;
  localparam grp_t GrpZfh      = 4'd6;
  localparam grp_t GrpV        = 4'd7;
  localparam grp_t GrpZicsr    = 4'd8;
  localparam grp_t GrpZifencei = 4'd9;

  // Major opcodes
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpMisc   = 7'h0F;
  localparam logic [6:0] OpSystem = 7'h73;
  localparam logic [6:0] OpImm32  = 7'h1B;
  localparam logic [6:0] OpReg32  = 7'h3B;
  localparam logic [6:0] OpAmo    = 7'h2F;
  localparam logic [6:0] OpFload  = 7'h07;
  localparam logic [6:0] OpFstore = 7'h27;
  localparam logic [6:0] OpFmadd  = 7'h43;
  localparam logic [6:0] OpFmsub  = 7'h47;
  localparam logic [6:0] OpFnmsub = 7'h4B;
  localparam logic [6:0] OpFnmadd = 7'h4F;
  localparam logic [6:0] OpFp     = 7'h53;
  localparam logic [6:0] OpVec    = 7'h57;

  // Mnemonic codes (subset named; runs are addressed by offset)
  localparam code_t MnLui = 8'd1,   MnAuipc = 8'd2, MnJal = 8'd3, MnJalr = 8'd4;
  localparam code_t MnBeq = 8'd5,   MnBne = 8'd6,   MnBlt = 8'd7, MnBge = 8'd8;
  localparam code_t MnBltu = 8'd9,  MnBgeu = 8'd10;
  localparam code_t MnLb = 8'd11,   MnLh = 8'd12,   MnLw = 8'd13, MnLbu = 8'd14;
  localparam code_t MnLhu = 8'd15,  MnLwu = 8'd16,  MnLd = 8'd17;
  localparam code_t MnSb = 8'd18;
  localparam code_t MnAddi = 8'd22, MnSlti = 8'd23, MnSltiu = 8'd24, MnXori = 8'd25;
  localparam code_t MnOri = 8'd26,  MnAndi = 8'd27, MnSlli = 8'd28, MnSrli = 8'd29;
  localparam code_t MnSrai = 8'd30;
  localparam code_t MnAdd = 8'd31,  MnSub = 8'd32,  MnMul = 8'd33, MnSll = 8'd34;
  localparam code_t MnMulh = 8'd35, MnSlt = 8'd36,  MnMulhsu = 8'd37, MnSltu = 8'd38;
  localparam code_t MnMulhu = 8'd39, MnXor = 8'd40, MnDiv = 8'd41, MnSrl = 8'd42;
  localparam code_t MnSra = 8'd43,  MnDivu = 8'd44, MnOr = 8'd45, MnRem = 8'd46;
  localparam code_t MnAnd = 8'd47,  MnRemu = 8'd48;
  localparam code_t MnFenceTso = 8'd49, MnPause = 8'd50, MnFence = 8'd51, MnFenceI = 8'd52;
  localparam code_t MnEcall = 8'd53, MnEbreak = 8'd54, MnCsrrw = 8'd55, MnCsrrwi = 8'd58;
  localparam code_t MnAddiw = 8'd61, MnSlliw = 8'd62, MnSrliw = 8'd63, MnSraiw = 8'd64;
  localparam code_t MnAddw = 8'd65, MnMulw = 8'd66, MnSubw = 8'd67, MnSllw = 8'd68;
  localparam code_t MnDivw = 8'd69, MnSrlw = 8'd70, MnSraw = 8'd71, MnDivuw = 8'd72;
  localparam code_t MnRemw = 8'd73, MnRemuw = 8'd74;
  localparam code_t MnLrW = 8'd75,  MnLrD = 8'd86;
  localparam code_t MnFlw = 8'd97,  MnFld = 8'd98,  MnFlq = 8'd99, MnFlh = 8'd100;
  localparam code_t MnVle64 = 8'd101, MnVle32 = 8'd102, MnVle16 = 8'd103, MnVle8 = 8'd104;
  localparam code_t MnFsw = 8'd105, MnFsd = 8'd106, MnFsq = 8'd107, MnFsh = 8'd108;
  localparam code_t MnVse64 = 8'd109, MnVse32 = 8'd110, MnVse16 = 8'd111, MnVse8 = 8'd112;
  localparam code_t MnFmaddS = 8'd113, MnFmsubS = 8'd117, MnFnmsubS = 8'd121;
  localparam code_t MnFnmaddS = 8'd125, MnFaddS = 8'd129, MnFsqrtS = 8'd145;
  localparam code_t MnFsgnjS = 8'd149, MnFminS = 8'd161;
  localparam code_t MnFcvtWS = 8'd169, MnFcvtWD = 8'd173;
  localparam code_t MnFcvtSD = 8'd177, MnFcvtSQ = 8'd178, MnFcvtSH = 8'd179;
  localparam code_t MnFcvtHS = 8'd180, MnFcvtHD = 8'd181, MnFcvtHQ = 8'd182;
  localparam code_t MnFcvtDS = 8'd183, MnFcvtDQ = 8'd184, MnFcvtDH = 8'd185;
  localparam code_t MnFcvtQS = 8'd186, MnFcvtQD = 8'd187, MnFcvtQH = 8'd188;
  localparam code_t MnFcvtWH = 8'd189;
  localparam code_t MnFmvXW = 8'd193, MnFmvXD = 8'd195, MnFclassQ = 8'd197;
  localparam code_t MnFclassH = 8'd198, MnFmvXH = 8'd199;
  localparam code_t MnFeqS = 8'd200;
  localparam code_t MnFcvtSW = 8'd212, MnFcvtDW = 8'd216, MnFcvtWQ = 8'd220;
  localparam code_t MnFcvtQW = 8'd224, MnFcvtHW = 8'd228;
  localparam code_t MnFmvHX = 8'd232, MnFmvWX = 8'd233, MnFmvDX = 8'd234;
  localparam code_t MnVaddIvv = 8'd235, MnVsubIvv = 8'd236, MnVaddIvi = 8'd237;
  localparam code_t MnVrsubIvi = 8'd238, MnVaddIvx = 8'd239, MnVsubIvx = 8'd240;
  localparam code_t MnVrsubIvx = 8'd241, MnVsetvli = 8'd242, MnVsetivli = 8'd243;
  localparam code_t MnVsetvl = 8'd244;

  // Stage-one predecode, carried to the class decode stage
  typedef struct packed {
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rs2;
    logic       f12_zero;
    logic       f12_one;
    logic       fence_tso;
    logic       fence_pause;
  } pre_t;

  typedef struct packed {
    code_t code;
    grp_t  grp;
  } res_t;

  // FP format: position within an S,D,Q,H run
  function automatic code_t fmt_pos(input logic [1:0] fmt);
    case (fmt)
      2'b00:   fmt_pos = 8'd0;
      2'b01:   fmt_pos = 8'd1;
      2'b10:   fmt_pos = 8'd3;
      default: fmt_pos = 8'd2;
    endcase
  endfunction

  function automatic grp_t fmt_grp(input logic [1:0] fmt);
    case (fmt)
      2'b00:   fmt_grp = GrpF;
      2'b01:   fmt_grp = GrpD;
      2'b10:   fmt_grp = GrpZfh;
      default: fmt_grp = GrpQ;
    endcase
  endfunction

endpackage

// ----- rtl/rvdec_stage.sv -----
// Decode stage: classifies one predecoded word into code and group.
module rvdec_stage (
  input  rvdec_pkg::pre_t pre_i,
  output rvdec_pkg::res_t res_o
);
  import rvdec_pkg::*;

  logic [1:0] fmt;
  logic [4:0] f5;
  logic [3:0] amo_off;
  logic       amo_ok;
  code_t      pos;
  grp_t       fgrp;
  res_t       r;

  assign fmt  = pre_i.f7[1:0];
  assign pos  = fmt_pos(fmt);
  assign fgrp = fmt_grp(fmt);
  assign f5   = pre_i.f7[6:2];

  // AMO funct5 to offset in the LR..AMOMAXU run
  always_comb begin
    amo_ok  = 1'b1;
    amo_off = 4'd0;
    case (f5)
      5'h02:   amo_off = 4'd0;
      5'h03:   amo_off = 4'd1;
      5'h01:   amo_off = 4'd2;
      5'h00:   amo_off = 4'd3;
      5'h04:   amo_off = 4'd4;
      5'h0C:   amo_off = 4'd5;
      5'h08:   amo_off = 4'd6;
      5'h10:   amo_off = 4'd7;
      5'h14:   amo_off = 4'd8;
      5'h18:   amo_off = 4'd9;
      5'h1C:   amo_off = 4'd10;
      default: amo_ok = 1'b0;
    endcase
  end

  always_comb begin
    r = '0;
    unique case (pre_i.opcode)
      OpLui:   r = '{MnLui, GrpI};
      OpAuipc: r = '{MnAuipc, GrpI};
      OpJal:   r = '{MnJal, GrpI};
      OpJalr:  r = '{MnJalr, GrpI};
      OpBranch: begin
        case (pre_i.f3)
          3'd0: r = '{MnBeq, GrpI};
          3'd1: r = '{MnBne, GrpI};
          3'd4: r = '{MnBlt, GrpI};
          3'd5: r = '{MnBge, GrpI};
          3'd6: r = '{MnBltu, GrpI};
          3'd7: r = '{MnBgeu, GrpI};
          default: r = '0;
        endcase
      end
      OpLoad: begin
        case (pre_i.f3)
          3'd0: r = '{MnLb, GrpI};
          3'd1: r = '{MnLh, GrpI};
          3'd2: r = '{MnLw, GrpI};
          3'd3: r = '{MnLd, GrpI};
          3'd4: r = '{MnLbu, GrpI};
          3'd5: r = '{MnLhu, GrpI};
          3'd6: r = '{MnLwu, GrpI};
          default: r = '0;
        endcase
      end
      OpStore: if (!pre_i.f3[2]) r = '{MnSb + code_t'(pre_i.f3), GrpI};
      OpImm: begin
        case (pre_i.f3)
          3'd0: r = '{MnAddi, GrpI};
          3'd1: r = '{MnSlli, GrpI};
          3'd2: r = '{MnSlti, GrpI};
          3'd3: r = '{MnSltiu, GrpI};
          3'd4: r = '{MnXori, GrpI};
          3'd6: r = '{MnOri, GrpI};
          3'd7: r = '{MnAndi, GrpI};
          default: begin
            if (pre_i.f7[6:1] == 6'h00)      r = '{MnSrli, GrpI};
            else if (pre_i.f7[6:1] == 6'h10) r = '{MnSrai, GrpI};
          end
        endcase
      end
      OpReg: begin
        if (pre_i.f7 == 7'h00) begin
          case (pre_i.f3)
            3'd0: r = '{MnAdd, GrpI};
            3'd1: r = '{MnSll, GrpI};
            3'd2: r = '{MnSlt, GrpI};
            3'd3: r = '{MnSltu, GrpI};
            3'd4: r = '{MnXor, GrpI};
            3'd5: r = '{MnSrl, GrpI};
            3'd6: r = '{MnOr, GrpI};
            default: r = '{MnAnd, GrpI};
          endcase
        end else if (pre_i.f7 == 7'h01) begin
          case (pre_i.f3)
            3'd0: r = '{MnMul, GrpM};
            3'd1: r = '{MnMulh, GrpM};
            3'd2: r = '{MnMulhsu, GrpM};
            3'd3: r = '{MnMulhu, GrpM};
            3'd4: r = '{MnDiv, GrpM};
            3'd5: r = '{MnDivu, GrpM};
            3'd6: r = '{MnRem, GrpM};
            default: r = '{MnRemu, GrpM};
          endcase
        end else if (pre_i.f7 == 7'h20 && pre_i.f3 == 3'd0) r = '{MnSub, GrpI};
        else if (pre_i.f7 == 7'h20 && pre_i.f3 == 3'd5) r = '{MnSra, GrpI};
      end
      OpMisc: begin
        if (pre_i.f3 == 3'd1) r = '{MnFenceI, GrpZifencei};
        else if (pre_i.f3 == 3'd0) begin
          if (pre_i.fence_tso)        r = '{MnFenceTso, GrpI};
          else if (pre_i.fence_pause) r = '{MnPause, GrpI};
          else                        r = '{MnFence, GrpI};
        end
      end
      OpSystem: begin
        case (pre_i.f3)
          3'd0: begin
            if (pre_i.f12_zero)     r = '{MnEcall, GrpI};
            else if (pre_i.f12_one) r = '{MnEbreak, GrpI};
          end
          3'd1, 3'd2, 3'd3: r = '{MnCsrrw + code_t'(pre_i.f3) - 8'd1, GrpZicsr};
          3'd5, 3'd6, 3'd7: r = '{MnCsrrwi + code_t'(pre_i.f3) - 8'd5, GrpZicsr};
          default: r = '0;
        endcase
      end
      OpImm32: begin
        if (pre_i.f3 == 3'd0)                           r = '{MnAddiw, GrpI};
        else if (pre_i.f3 == 3'd1)                      r = '{MnSlliw, GrpI};
        else if (pre_i.f3 == 3'd5 && pre_i.f7 == 7'h00) r = '{MnSrliw, GrpI};
        else if (pre_i.f3 == 3'd5 && pre_i.f7 == 7'h20) r = '{MnSraiw, GrpI};
      end
      OpReg32: begin
        case (pre_i.f3)
          3'd0: begin
            if (pre_i.f7 == 7'h00)      r = '{MnAddw, GrpI};
            else if (pre_i.f7 == 7'h01) r = '{MnMulw, GrpM};
            else if (pre_i.f7 == 7'h20) r = '{MnSubw, GrpI};
          end
          3'd1: r = '{MnSllw, GrpI};
          3'd4: r = '{MnDivw, GrpM};
          3'd5: begin
            if (pre_i.f7 == 7'h00)      r = '{MnSrlw, GrpI};
            else if (pre_i.f7 == 7'h20) r = '{MnSraw, GrpI};
            else if (pre_i.f7 == 7'h01) r = '{MnDivuw, GrpM};
          end
          3'd6: r = '{MnRemw, GrpM};
          3'd7: r = '{MnRemuw, GrpM};
          default: r = '0;
        endcase
      end
      OpAmo: begin
        if (amo_ok && pre_i.f3 == 3'd2) r = '{MnLrW + code_t'(amo_off), GrpA};
        else if (amo_ok && pre_i.f3 == 3'd3) r = '{MnLrD + code_t'(amo_off), GrpA};
      end
      OpFload, OpFstore: begin
        case (pre_i.f3)
          3'd0: r = '{MnVle8, GrpV};
          3'd1: r = '{MnFlh, GrpZfh};
          3'd2: r = '{MnFlw, GrpF};
          3'd3: r = '{MnFld, GrpD};
          3'd4: r = '{MnFlq, GrpQ};
          3'd5: r = '{MnVle16, GrpV};
          3'd6: r = '{MnVle32, GrpV};
          default: r = '{MnVle64, GrpV};
        endcase
        // stores follow the loads by eight codes
        if (pre_i.opcode == OpFstore) r.code = r.code + (MnFsw - MnFlw);
      end
      OpFmadd:  r = '{MnFmaddS + pos, fgrp};
      OpFmsub:  r = '{MnFmsubS + pos, fgrp};
      OpFnmsub: r = '{MnFnmsubS + pos, fgrp};
      OpFnmadd: r = '{MnFnmaddS + pos, fgrp};
      OpFp: begin
        case (f5)
          5'h00, 5'h01, 5'h02, 5'h03:
            r = '{MnFaddS + code_t'({f5, 2'b00}) + pos, fgrp};
          5'h0B: r = '{MnFsqrtS + pos, fgrp};
          5'h04: if (pre_i.f3 < 3'd3)
            r = '{MnFsgnjS + 8'd3 * pos + code_t'(pre_i.f3), fgrp};
          5'h05: if (pre_i.f3 < 3'd2)
            r = '{MnFminS + {pos[6:0], 1'b0} + code_t'(pre_i.f3), fgrp};
          5'h14: if (pre_i.f3 < 3'd3)
            r = '{MnFeqS + 8'd3 * pos + 8'd2 - code_t'(pre_i.f3), fgrp};
          5'h18: if (pre_i.rs2 < 5'd4) begin
            case (fmt)
              2'b00:   r.code = MnFcvtWS;
              2'b01:   r.code = MnFcvtWD;
              2'b10:   r.code = MnFcvtWH;
              default: r.code = MnFcvtWQ;
            endcase
            r.code = r.code + code_t'(pre_i.rs2);
            r.grp  = fgrp;
          end
          5'h1A: if (pre_i.rs2 < 5'd4) begin
            case (fmt)
              2'b00:   r.code = MnFcvtSW;
              2'b01:   r.code = MnFcvtDW;
              2'b10:   r.code = MnFcvtHW;
              default: r.code = MnFcvtQW;
            endcase
            r.code = r.code + code_t'(pre_i.rs2);
            r.grp  = fgrp;
          end
          default: begin
            case (pre_i.f7)
              7'h20: begin
                if (pre_i.rs2 == 5'd1)      r = '{MnFcvtSD, GrpD};
                else if (pre_i.rs2 == 5'd3) r = '{MnFcvtSQ, GrpQ};
                else if (pre_i.rs2 == 5'd2) r = '{MnFcvtSH, GrpZfh};
              end
              7'h22: begin
                if (pre_i.rs2 == 5'd0)      r = '{MnFcvtHS, GrpZfh};
                else if (pre_i.rs2 == 5'd1) r = '{MnFcvtHD, GrpZfh};
                else if (pre_i.rs2 == 5'd3) r = '{MnFcvtHQ, GrpZfh};
              end
              7'h21: begin
                if (pre_i.rs2 == 5'd0)      r = '{MnFcvtDS, GrpD};
                else if (pre_i.rs2 == 5'd3) r = '{MnFcvtDQ, GrpQ};
                else if (pre_i.rs2 == 5'd2) r = '{MnFcvtDH, GrpZfh};
              end
              7'h23: begin
                if (pre_i.rs2 == 5'd0)      r = '{MnFcvtQS, GrpQ};
                else if (pre_i.rs2 == 5'd1) r = '{MnFcvtQD, GrpQ};
                else if (pre_i.rs2 == 5'd2) r = '{MnFcvtQH, GrpZfh};
              end
              7'h70: if (pre_i.f3 < 3'd2) r = '{MnFmvXW + code_t'(pre_i.f3), GrpF};
              7'h71: if (pre_i.f3 < 3'd2) r = '{MnFmvXD + code_t'(pre_i.f3), GrpD};
              7'h73: if (pre_i.f3 == 3'd1) r = '{MnFclassQ, GrpQ};
              7'h72: begin
                if (pre_i.f3 == 3'd1)      r = '{MnFclassH, GrpZfh};
                else if (pre_i.f3 == 3'd0) r = '{MnFmvXH, GrpZfh};
              end
              7'h7A: r = '{MnFmvHX, GrpZfh};
              7'h78: r = '{MnFmvWX, GrpF};
              7'h79: r = '{MnFmvDX, GrpD};
              default: r = '0;
            endcase
          end
        endcase
      end
      OpVec: begin
        case (pre_i.f3)
          3'd0: begin
            if (pre_i.f7[6:1] == 6'd0)      r = '{MnVaddIvv, GrpV};
            else if (pre_i.f7[6:1] == 6'd2) r = '{MnVsubIvv, GrpV};
          end
          3'd3: begin
            if (pre_i.f7[6:1] == 6'd0)      r = '{MnVaddIvi, GrpV};
            else if (pre_i.f7[6:1] == 6'd3) r = '{MnVrsubIvi, GrpV};
          end
          3'd4: begin
            if (pre_i.f7[6:1] == 6'd0)      r = '{MnVaddIvx, GrpV};
            else if (pre_i.f7[6:1] == 6'd2) r = '{MnVsubIvx, GrpV};
            else if (pre_i.f7[6:1] == 6'd3) r = '{MnVrsubIvx, GrpV};
          end
          3'd7: begin
            if (!pre_i.f7[6])     r = '{MnVsetvli, GrpV};
            else if (pre_i.f7[5]) r = '{MnVsetivli, GrpV};
            else                  r = '{MnVsetvl, GrpV};
          end
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
  end

  assign res_o = r;

endmodule

// ----- rtl/rv64_instruction_class_decoder_core.sv -----
// RV64 instruction class decoder.
// Request channel: drive instr_word_i with start_i high; the word is taken at
// any rising edge where busy_o is low. busy_o is tied low: one word can be
// taken every cycle.
// Result channel: done_o pulses for one cycle with is_valid_o, mnemonic_code_o
// and extension_group_o. There is no back-pressure; the result must be taken
// in that cycle.
// The result passes through three register stages (field predecode, class
// decode, output register) between the accepting edge and done_o.
// Throughput: one word per cycle, since busy_o never rises.
// Invalid words give is_valid_o 0, code 0, group 0.
// Reset clears the stage valid bits; words in flight are dropped and done_o
// stays low until new requests reach the output.
module rv64_instruction_class_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [rvdec_pkg::InstrWidth-1:0] instr_word_i,
  output logic                             done_o,
  output logic                             is_valid_o,
  output logic [rvdec_pkg::CodeWidth-1:0]  mnemonic_code_o,
  output logic [rvdec_pkg::GroupWidth-1:0] extension_group_o
);
  import rvdec_pkg::*;

  logic v1_q, v2_q, v3_q;
  pre_t pre_d, pre_q;
  res_t res_d, res_q;
  logic ok_q;
  code_t code_q;
  grp_t grp_q;

  assign busy_o = 1'b0;

  // Stage 1: field extraction and wide compares
  always_comb begin
    pre_d.opcode      = instr_word_i[6:0];
    pre_d.f3          = instr_word_i[14:12];
    pre_d.f7          = instr_word_i[31:25];
    pre_d.rs2         = instr_word_i[24:20];
    pre_d.f12_zero    = instr_word_i[31:20] == 12'h000;
    pre_d.f12_one     = instr_word_i[31:20] == 12'h001;
    pre_d.fence_tso   = instr_word_i[31:20] == 12'h833;
    pre_d.fence_pause = instr_word_i[31:20] == 12'h010;
  end

  // Stage 2: class decode
  rvdec_stage u_stage (
    .pre_i (pre_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q  <= pre_d;
    res_q  <= res_d;
    ok_q   <= res_q.code != '0;
    code_q <= res_q.code;
    grp_q  <= (res_q.code != '0) ? res_q.grp : '0;
  end

  assign done_o            = v3_q;
  assign is_valid_o        = ok_q;
  assign mnemonic_code_o   = code_q;
  assign extension_group_o = grp_q;

  // Checks
  a_valid_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_valid_o == (mnemonic_code_o != '0))) else $error("valid/code mismatch");
  a_inv_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_valid_o) |-> extension_group_o == '0) else $error("group on invalid");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##2 done_o) else $error("result lost");

endmodule

// ----- bench/tb_rv64_instruction_class_decoder_core.sv -----
`timescale 1ns / 1ps

module tb_rv64_instruction_class_decoder_core;
  import rvdec_pkg::*;

  // Offsets of named codes inside the dense mnemonic list
  localparam int unsigned SbOfs = 18;
  localparam int unsigned FaddS = 129;
  localparam int unsigned FsqrtS = 145;
  localparam int unsigned FsgnjS = 149;
  localparam int unsigned FminS = 161;
  localparam int unsigned FeqS = 200;
  localparam int unsigned CsrrwiOfs = 58;
  localparam int unsigned WatchLimit = 2000;

  typedef struct packed {
    logic  ok;
    code_t code;
    grp_t  grp;
  } dec_t;

  // Expected decode for one instruction word
  function automatic dec_t decode_word(logic [31:0] w);
    logic [2:0] f3;
    logic [6:0] f7;
    logic [1:0] fmt;
    logic [4:0] rs2;
    logic [5:0] f6;
    code_t c;
    grp_t g;
    code_t pos;
    grp_t fg;
    dec_t r;
    f3 = w[14:12]; f7 = w[31:25]; fmt = w[26:25]; rs2 = w[24:20]; f6 = w[31:26];
    pos = fmt_pos_m(fmt); fg = fmt_grp_m(fmt);
    c = '0; g = GrpI;
    case (w[6:0])
      OpLui: c = MnLui;
      OpAuipc: c = MnAuipc;
      OpJal: c = MnJal;
      OpJalr: c = MnJalr;
      OpBranch: begin
        case (f3)
          3'd0: c = MnBeq; 3'd1: c = MnBne; 3'd4: c = MnBlt;
          3'd5: c = MnBge; 3'd6: c = MnBltu; 3'd7: c = MnBgeu;
          default: c = '0;
        endcase
      end
      OpLoad: begin
        case (f3)
          3'd0: c = MnLb; 3'd1: c = MnLh; 3'd2: c = MnLw; 3'd3: c = MnLd;
          3'd4: c = MnLbu; 3'd5: c = MnLhu; 3'd6: c = MnLwu;
          default: c = '0;
        endcase
      end
      OpStore: if (f3 < 4) c = code_t'(SbOfs + f3);
      OpImm: begin
        case (f3)
          3'd0: c = MnAddi; 3'd1: c = MnSlli; 3'd2: c = MnSlti; 3'd3: c = MnSltiu;
          3'd4: c = MnXori; 3'd6: c = MnOri; 3'd7: c = MnAndi;
          default: begin
            if (f6 == 6'h00) c = MnSrli;
            else if (f6 == 6'h10) c = MnSrai;
          end
        endcase
      end
      OpReg: begin
        if (f7 == 7'h00) begin
          case (f3)
            3'd0: c = MnAdd; 3'd1: c = MnSll; 3'd2: c = MnSlt; 3'd3: c = MnSltu;
            3'd4: c = MnXor; 3'd5: c = MnSrl; 3'd6: c = MnOr; default: c = MnAnd;
          endcase
        end else if (f7 == 7'h01) begin
          g = GrpM;
          case (f3)
            3'd0: c = MnMul; 3'd1: c = MnMulh; 3'd2: c = MnMulhsu; 3'd3: c = MnMulhu;
            3'd4: c = MnDiv; 3'd5: c = MnDivu; 3'd6: c = MnRem; default: c = MnRemu;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) c = MnSub;
        else if (f7 == 7'h20 && f3 == 3'd5) c = MnSra;
      end
      OpMisc: begin
        if (f3 == 3'd1) begin
          c = MnFenceI; g = GrpZifencei;
        end else if (f3 == 3'd0) begin
          if (w[31:20] == 12'h833) c = MnFenceTso;
          else if (w[31:20] == 12'h010) c = MnPause;
          else c = MnFence;
        end
      end
      OpSystem: begin
        if (f3 == 3'd0) begin
          if (w[31:20] == 12'd0) c = MnEcall;
          else if (w[31:20] == 12'd1) c = MnEbreak;
        end else if (f3 != 3'd4) begin
          g = GrpZicsr;
          c = code_t'((f3 < 4) ? MnCsrrw + f3 - 1 : CsrrwiOfs + f3 - 5);
        end
      end
      OpImm32: begin
        if (f3 == 3'd0) c = MnAddiw;
        else if (f3 == 3'd1) c = MnSlliw;
        else if (f3 == 3'd5 && f7 == 7'h00) c = MnSrliw;
        else if (f3 == 3'd5 && f7 == 7'h20) c = MnSraiw;
      end
      OpReg32: begin
        case (f3)
          3'd0: begin
            if (f7 == 7'h00) c = MnAddw;
            else if (f7 == 7'h01) begin c = MnMulw; g = GrpM; end
            else if (f7 == 7'h20) c = MnSubw;
          end
          3'd1: c = MnSllw;
          3'd4: begin c = MnDivw; g = GrpM; end
          3'd5: begin
            if (f7 == 7'h00) c = MnSrlw;
            else if (f7 == 7'h20) c = MnSraw;
            else if (f7 == 7'h01) begin c = MnDivuw; g = GrpM; end
          end
          3'd6: begin c = MnRemw; g = GrpM; end
          3'd7: begin c = MnRemuw; g = GrpM; end
          default: c = '0;
        endcase
      end
      OpAmo: begin
        int ofs;
        ofs = amo_ofs(w[31:27]);
        if (ofs >= 0 && (f3 == 3'd2 || f3 == 3'd3)) begin
          c = code_t'(((f3 == 3'd2) ? MnLrW : MnLrD) + ofs); g = GrpA;
        end
      end
      OpFload, OpFstore: begin
        case (f3)
          3'd0: begin c = MnVle8; g = GrpV; end
          3'd1: begin c = MnFlh; g = GrpZfh; end
          3'd2: begin c = MnFlw; g = GrpF; end
          3'd3: begin c = MnFld; g = GrpD; end
          3'd4: begin c = MnFlq; g = GrpQ; end
          3'd5: begin c = MnVle16; g = GrpV; end
          3'd6: begin c = MnVle32; g = GrpV; end
          default: begin c = MnVle64; g = GrpV; end
        endcase
        if (w[6:0] == OpFstore) c = c + 8'd8;
      end
      OpFmadd: begin c = MnFmaddS + pos; g = fg; end
      OpFmsub: begin c = MnFmsubS + pos; g = fg; end
      OpFnmsub: begin c = MnFnmsubS + pos; g = fg; end
      OpFnmadd: begin c = MnFnmaddS + pos; g = fg; end
      OpFp: begin
        g = fg;
        case (f7[6:2])
          5'h00, 5'h01, 5'h02, 5'h03: c = code_t'(FaddS + 4 * f7[6:2] + pos);
          5'h0B: c = code_t'(FsqrtS + pos);
          5'h04: if (f3 < 3) c = code_t'(FsgnjS + 3 * pos + f3);
          5'h05: if (f3 < 2) c = code_t'(FminS + 2 * pos + f3);
          5'h14: if (f3 < 3) c = code_t'(FeqS + 3 * pos + (2 - f3));
          5'h18: if (rs2 < 4) c = cvt_to(fmt) + code_t'(rs2);
          5'h1A: if (rs2 < 4) c = cvt_from(fmt) + code_t'(rs2);
          default: begin
            case (f7)
              7'h20: begin
                if (rs2 == 1) begin c = MnFcvtSD; g = GrpD; end
                else if (rs2 == 3) begin c = MnFcvtSQ; g = GrpQ; end
                else if (rs2 == 2) begin c = MnFcvtSH; g = GrpZfh; end
              end
              7'h22: begin
                g = GrpZfh;
                if (rs2 == 0) c = MnFcvtHS;
                else if (rs2 == 1) c = MnFcvtHD;
                else if (rs2 == 3) c = MnFcvtHQ;
              end
              7'h21: begin
                if (rs2 == 0) begin c = MnFcvtDS; g = GrpD; end
                else if (rs2 == 3) begin c = MnFcvtDQ; g = GrpQ; end
                else if (rs2 == 2) begin c = MnFcvtDH; g = GrpZfh; end
              end
              7'h23: begin
                g = GrpQ;
                if (rs2 == 0) c = MnFcvtQS;
                else if (rs2 == 1) c = MnFcvtQD;
                else if (rs2 == 2) begin c = MnFcvtQH; g = GrpZfh; end
              end
              7'h70: begin g = GrpF; if (f3 < 2) c = MnFmvXW + code_t'(f3); end
              7'h71: begin g = GrpD; if (f3 < 2) c = MnFmvXD + code_t'(f3); end
              7'h73: begin g = GrpQ; if (f3 == 1) c = MnFclassQ; end
              7'h72: begin
                g = GrpZfh;
                if (f3 == 1) c = MnFclassH;
                else if (f3 == 0) c = MnFmvXH;
              end
              7'h7A: begin c = MnFmvHX; g = GrpZfh; end
              7'h78: begin c = MnFmvWX; g = GrpF; end
              7'h79: begin c = MnFmvDX; g = GrpD; end
              default: c = '0;
            endcase
          end
        endcase
      end
      OpVec: begin
        g = GrpV;
        case (f3)
          3'd0: begin
            if (f6 == 0) c = MnVaddIvv; else if (f6 == 2) c = MnVsubIvv;
          end
          3'd3: begin
            if (f6 == 0) c = MnVaddIvi; else if (f6 == 3) c = MnVrsubIvi;
          end
          3'd4: begin
            if (f6 == 0) c = MnVaddIvx;
            else if (f6 == 2) c = MnVsubIvx;
            else if (f6 == 3) c = MnVrsubIvx;
          end
          3'd7: begin
            if (!w[31]) c = MnVsetvli;
            else if (w[30]) c = MnVsetivli;
            else c = MnVsetvl;
          end
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    r.ok = (c != 0);
    r.code = c;
    r.grp = r.ok ? g : GrpI;
    return r;
  endfunction

  function automatic code_t fmt_pos_m(logic [1:0] f);
    case (f)
      2'b00: return 8'd0;
      2'b01: return 8'd1;
      2'b10: return 8'd3;
      default: return 8'd2;
    endcase
  endfunction

  function automatic grp_t fmt_grp_m(logic [1:0] f);
    case (f)
      2'b00: return GrpF;
      2'b01: return GrpD;
      2'b10: return GrpZfh;
      default: return GrpQ;
    endcase
  endfunction

  function automatic code_t cvt_to(logic [1:0] f);
    case (f)
      2'b00: return MnFcvtWS;
      2'b01: return MnFcvtWD;
      2'b10: return MnFcvtWH;
      default: return MnFcvtWQ;
    endcase
  endfunction

  function automatic code_t cvt_from(logic [1:0] f);
    case (f)
      2'b00: return MnFcvtSW;
      2'b01: return MnFcvtDW;
      2'b10: return MnFcvtHW;
      default: return MnFcvtQW;
    endcase
  endfunction

  // Position of an atomic funct5 inside the LR..AMOMAXU run, -1 if none
  function automatic int amo_ofs(logic [4:0] f5);
    case (f5)
      5'h02: return 0; 5'h03: return 1; 5'h01: return 2; 5'h00: return 3;
      5'h04: return 4; 5'h0C: return 5; 5'h08: return 6; 5'h10: return 7;
      5'h14: return 8; 5'h18: return 9; 5'h1C: return 10;
      default: return -1;
    endcase
  endfunction

  // Holds decodes of accepted requests and checks results in order
  class decode_scoreboard;
    dec_t pending[$];
    int errors;

    function void note_request(logic [31:0] w);
      pending.push_back(decode_word(w));
    endfunction

    function void check_result(logic v, code_t c, grp_t g);
      dec_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: v=%0d code=%0d grp=%0d", v, c, g);
        return;
      end
      e = pending.pop_front();
      if (e.ok !== v || e.code !== c || e.grp !== g) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp v=%0d code=%0d grp=%0d got v=%0d code=%0d grp=%0d",
                   e.ok, e.code, e.grp, v, c, g);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [31:0] instr_word_i = '0;
  logic busy_o, done_o, is_valid_o;
  logic [CodeWidth-1:0] mnemonic_code_o;
  logic [GroupWidth-1:0] extension_group_o;

  decode_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  rv64_instruction_class_decoder_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .instr_word_i,
    .done_o, .is_valid_o, .mnemonic_code_o, .extension_group_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(is_valid_o, mnemonic_code_o, extension_group_o);
      if (done_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one request, with random idle cycles first
  task automatic send_request(logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    instr_word_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(w);
  endtask

  // Random word, mostly on a known opcode with a random body
  function automatic logic [31:0] random_word();
    logic [6:0] ops[22];
    logic [31:0] w;
    ops = '{OpLui, OpAuipc, OpJal, OpJalr, OpBranch, OpLoad, OpStore, OpImm, OpReg,
            OpMisc, OpSystem, OpImm32, OpReg32, OpAmo, OpFload, OpFstore, OpFmadd,
            OpFmsub, OpFnmsub, OpFnmadd, OpFp, OpVec};
    w = $urandom;
    if ($urandom_range(9) < 9) begin
      w[6:0] = ops[$urandom_range(21)];
      // bias toward encodings the decoder accepts
      case ($urandom_range(3))
        0: w[31:25] = $urandom_range(1) ? 7'h00 : ($urandom_range(1) ? 7'h01 : 7'h20);
        1: w[24:20] = 5'($urandom_range(4));
        2: if (w[6:0] == OpSystem) w[31:21] = '0;
        default: ;
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$];
    sb = new();
    quiet_cycles = 0;
    idle_pct = 22;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and special encodings: fences, pause, system, atomics, vsetvl forms
    directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8330_000F, 32'h0100_000F,
                 32'h0FF0_000F, 32'h0000_100F, 32'h0000_0073, 32'h0010_0073,
                 32'h0020_0073, 32'h0000_4073, 32'h1000_202F, 32'h0000_302F,
                 32'h0000_102F, 32'hF800_202F, 32'hFE00_5013, 32'h4200_5013,
                 32'h0200_5013, 32'h0000_7057, 32'hC000_7057, 32'h8000_7057,
                 32'h0C00_4057, 32'hE000_0053, 32'hF400_0053, 32'h4030_0053,
                 32'hD060_0053};
    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < 1350; n++) begin
      if (n == 450) idle_pct = 60;
      if (n == 900) idle_pct = 0;
      if (n == 700) begin
        // hold off until the pipeline drains
        start_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      send_request(random_word());
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
